FILE: design/cvs_pkg.sv
// shared types, codes and constants of the velocity command shaper
package cvs_pkg;

    localparam int NUM_AXES = 3;
    localparam int AXIS_W   = $clog2(NUM_AXES);
    localparam int COORD_W  = 32;
    localparam int LIMIT_W  = 31;
    localparam int GAIN_W   = 16;
    localparam int WEIGHT_W = 17;
    localparam int PROD_W   = 50;
    localparam int ACTION_W = 3;
    localparam int CFG_IDX_W = 3;

    localparam int W_ONE      = 65536;
    localparam int ROUND_HALF = 32768;

    typedef logic signed [COORD_W-1:0]  t_coord;
    typedef logic        [LIMIT_W-1:0]  t_limit;
    typedef logic        [GAIN_W-1:0]   t_gain;
    typedef logic        [WEIGHT_W-1:0] t_weight;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic        [ACTION_W-1:0] t_action;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic        [AXIS_W-1:0]   t_axis;

    localparam t_action ACT_TICK       = 3'd0;
    localparam t_action ACT_SPEED      = 3'd1;
    localparam t_action ACT_GOAL       = 3'd2;
    localparam t_action ACT_ACTIVATE   = 3'd3;
    localparam t_action ACT_DEACTIVATE = 3'd4;

    localparam t_cfg_idx CFG_PROP_GAIN   = 3'd0;
    localparam t_cfg_idx CFG_LIM_VEL_X   = 3'd1;
    localparam t_cfg_idx CFG_LIM_VEL_Y   = 3'd2;
    localparam t_cfg_idx CFG_LIM_VEL_Z   = 3'd3;
    localparam t_cfg_idx CFG_LIM_DISP_X  = 3'd4;
    localparam t_cfg_idx CFG_LIM_POS_X   = 3'd5;
    localparam t_cfg_idx CFG_SMOOTH_W    = 3'd6;

endpackage

FILE: design/cvs_ifs.sv
// valid/ready channels of the velocity command shaper

interface cvs_item_if;
    logic             valid;
    logic             ready;
    cvs_pkg::t_action action;
    cvs_pkg::t_coord  coord_x;
    cvs_pkg::t_coord  coord_y;
    cvs_pkg::t_coord  coord_z;

    modport source (output valid, action, coord_x, coord_y, coord_z, input ready);
    modport sink   (input valid, action, coord_x, coord_y, coord_z, output ready);
endinterface

interface cvs_result_if;
    logic            valid;
    logic            ready;
    cvs_pkg::t_coord cmd_vel_x;
    cvs_pkg::t_coord cmd_vel_y;
    cvs_pkg::t_coord cmd_vel_z;
    logic            limit_tripped;
    logic            in_position_mode;

    modport source (output valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, limit_tripped,
                    in_position_mode, input ready);
    modport sink   (input valid, cmd_vel_x, cmd_vel_y, cmd_vel_z, limit_tripped,
                    in_position_mode, output ready);
endinterface

interface cvs_cfg_if;
    logic              valid;
    logic              ready;
    cvs_pkg::t_cfg_idx index;
    logic [31:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/cartesian_velocity_command_shaper.sv
// top level of the three-axis velocity command shaper
// Accepts speed targets, position goals, activate/deactivate and tick items on one
// channel; only ticks of an active block give a result (smoothed x/y/z velocity
// commands, limit trip flag, mode). Non-tick items leave the block idle and ready. A
// tick holds off the next item while one shared subtract-multiply unit works through
// a multiply and a clamp state per axis for the P term (position mode only), then a
// state for the start latch and x limit check, a multiply and an accumulate state per
// axis for smoothing, and a state that loads the output register. The output
// register holds a result until it is taken; a finished tick waits for it to free.
// Configuration writes are taken in any cycle but are meant for an idle block.
module cartesian_velocity_command_shaper (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cvs_item_if.sink      i_item,
    cvs_result_if.source  o_res,
    cvs_cfg_if.sink       i_cfg
);
    import cvs_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PMUL   = 3'd1;
    localparam logic [2:0] ST_PCLAMP = 3'd2;
    localparam logic [2:0] ST_TRIP   = 3'd3;
    localparam logic [2:0] ST_SMUL   = 3'd4;
    localparam logic [2:0] ST_SACC   = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam t_axis LAST_AXIS = AXIS_W'(NUM_AXES - 1);
    localparam int    P_W       = PROD_W - 8;

    function automatic t_coord clamp_mag(input logic signed [P_W-1:0] v,
                                         input t_limit lim);
        logic signed [P_W-1:0] pos_lim;
        logic signed [P_W-1:0] neg_lim;
        pos_lim = $signed({{(P_W-LIMIT_W){1'b0}}, lim});
        neg_lim = -pos_lim;
        if (v > pos_lim) begin
            return pos_lim[COORD_W-1:0];
        end else if (v < neg_lim) begin
            return neg_lim[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    // configuration
    t_gain   r_gain;
    t_limit  r_lim_vel [NUM_AXES];
    t_limit  r_lim_disp;
    t_coord  r_lim_pos;
    t_weight r_smooth_w;

    // block state
    logic [2:0] r_state, n_state;
    t_axis      r_axis, n_axis;
    t_coord     r_vel_target [NUM_AXES];
    t_coord     r_goal [NUM_AXES];
    t_coord     r_cmd [NUM_AXES];
    t_coord     r_start_x;
    t_coord     r_coord [NUM_AXES];
    logic       r_pos_mode;
    logic       r_relatch;
    logic       r_active;
    logic       r_tripped;

    // output register
    logic       r_out_valid;
    t_coord     r_out_cmd [NUM_AXES];
    logic       r_out_tripped;
    logic       r_out_pos_mode;

    t_coord     w_in_coord [NUM_AXES];
    logic       w_item_xfer;
    logic       w_out_free;
    t_weight    w_weight;
    logic       w_mac_en;
    t_coord     w_mac_a;
    t_coord     w_mac_b;
    t_weight    w_mac_k;
    t_prod      w_prod;
    t_coord     w_start;
    logic signed [COORD_W:0] w_dist;
    logic        [COORD_W:0] w_abs;
    logic       w_trip;
    t_prod      w_sum;

    assign w_in_coord[0] = i_item.coord_x;
    assign w_in_coord[1] = i_item.coord_y;
    assign w_in_coord[2] = i_item.coord_z;

    assign i_item.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign w_item_xfer  = i_item.valid && i_item.ready;
    assign w_out_free   = !r_out_valid || o_res.ready;

    assign w_weight = (r_smooth_w > WEIGHT_W'(W_ONE)) ? WEIGHT_W'(W_ONE) : r_smooth_w;

    // operand selection for the shared unit
    assign w_mac_en = (r_state == ST_PMUL) || (r_state == ST_SMUL);
    always_comb begin
        if (r_state == ST_PMUL) begin
            w_mac_a = r_goal[r_axis];
            w_mac_b = r_coord[r_axis];
            w_mac_k = {1'b0, r_gain};
        end else begin
            w_mac_a = r_vel_target[r_axis];
            w_mac_b = r_cmd[r_axis];
            w_mac_k = w_weight;
        end
    end

    cvs_mac u_mac (
        .i_clk        (i_clk),
        .i_en         (w_mac_en),
        .i_minuend    (w_mac_a),
        .i_subtrahend (w_mac_b),
        .i_scale      (w_mac_k),
        .o_prod       (w_prod)
    );

    // start latch and x safety check
    assign w_start = r_relatch ? r_coord[0] : r_start_x;
    assign w_dist  = {w_start[COORD_W-1], w_start} - {r_coord[0][COORD_W-1], r_coord[0]};
    assign w_abs   = w_dist[COORD_W] ? unsigned'(-w_dist) : unsigned'(w_dist);
    assign w_trip  = (w_abs > {2'b00, r_lim_disp}) || (r_coord[0] > r_lim_pos);

    // cmd + w*(target-cmd), rounded to nearest
    assign w_sum = $signed({{(PROD_W-COORD_W-16){r_cmd[r_axis][COORD_W-1]}},
                            r_cmd[r_axis], 16'b0})
                 + w_prod + PROD_W'(ROUND_HALF);

    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        unique case (r_state)
            ST_IDLE: begin
                n_axis = '0;
                if (w_item_xfer && i_item.action == ACT_TICK && r_active) begin
                    n_state = r_pos_mode ? ST_PMUL : ST_TRIP;
                end
            end
            ST_PMUL:   n_state = ST_PCLAMP;
            ST_PCLAMP: begin
                if (r_axis == LAST_AXIS) begin
                    n_state = ST_TRIP;
                    n_axis  = '0;
                end else begin
                    n_state = ST_PMUL;
                    n_axis  = r_axis + 1'b1;
                end
            end
            ST_TRIP: begin
                n_state = ST_SMUL;
                n_axis  = '0;
            end
            ST_SMUL:   n_state = ST_SACC;
            ST_SACC: begin
                if (r_axis == LAST_AXIS) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_SMUL;
                    n_axis  = r_axis + 1'b1;
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_axis      <= '0;
            r_gain      <= GAIN_W'(256);
            for (int i = 0; i < NUM_AXES; i++) begin
                r_lim_vel[i]    <= LIMIT_W'(6554);
                r_vel_target[i] <= '0;
                r_goal[i]       <= '0;
                r_cmd[i]        <= '0;
            end
            r_lim_disp  <= LIMIT_W'(6554);
            r_lim_pos   <= COORD_W'(65536);
            r_smooth_w  <= WEIGHT_W'(6554);
            r_start_x   <= '0;
            r_pos_mode  <= 1'b0;
            r_relatch   <= 1'b1;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;

            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.index)
                    CFG_PROP_GAIN:  r_gain       <= i_cfg.data[GAIN_W-1:0];
                    CFG_LIM_VEL_X:  r_lim_vel[0] <= i_cfg.data[LIMIT_W-1:0];
                    CFG_LIM_VEL_Y:  r_lim_vel[1] <= i_cfg.data[LIMIT_W-1:0];
                    CFG_LIM_VEL_Z:  r_lim_vel[2] <= i_cfg.data[LIMIT_W-1:0];
                    CFG_LIM_DISP_X: r_lim_disp   <= i_cfg.data[LIMIT_W-1:0];
                    CFG_LIM_POS_X:  r_lim_pos    <= i_cfg.data;
                    CFG_SMOOTH_W:   r_smooth_w   <= i_cfg.data[WEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // a new result may replace the one taken in the same cycle
            if (r_state == ST_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_item_xfer) begin
                        unique case (i_item.action)
                            ACT_ACTIVATE: begin
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    r_vel_target[i] <= '0;
                                    r_cmd[i]        <= '0;
                                end
                                r_active   <= 1'b1;
                                r_relatch  <= 1'b1;
                                r_pos_mode <= 1'b0;
                            end
                            ACT_DEACTIVATE: begin
                                r_active   <= 1'b0;
                                r_pos_mode <= 1'b0;
                            end
                            ACT_SPEED: begin
                                if (r_active) begin
                                    for (int i = 0; i < NUM_AXES; i++) begin
                                        r_vel_target[i] <= clamp_mag(
                                            P_W'(w_in_coord[i]), r_lim_vel[i]);
                                    end
                                    r_pos_mode <= 1'b0;
                                    r_relatch  <= 1'b1;
                                end
                            end
                            ACT_GOAL: begin
                                if (r_active) begin
                                    for (int i = 0; i < NUM_AXES; i++) begin
                                        r_goal[i] <= w_in_coord[i];
                                    end
                                    r_pos_mode <= 1'b1;
                                    r_relatch  <= 1'b1;
                                end
                            end
                            ACT_TICK: begin
                                for (int i = 0; i < NUM_AXES; i++) begin
                                    r_coord[i] <= w_in_coord[i];
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_PCLAMP: begin
                    r_vel_target[r_axis] <= clamp_mag(w_prod[PROD_W-1:8], r_lim_vel[r_axis]);
                end
                ST_TRIP: begin
                    r_start_x <= w_start;
                    r_relatch <= 1'b0;
                    r_tripped <= w_trip;
                    if (w_trip) begin
                        for (int i = 0; i < NUM_AXES; i++) begin
                            r_vel_target[i] <= '0;
                        end
                    end
                end
                ST_SACC: begin
                    r_cmd[r_axis] <= w_sum[COORD_W+15:16];
                end
                ST_OUT: begin
                    if (w_out_free) begin
                        r_out_cmd      <= r_cmd;
                        r_out_tripped  <= r_tripped;
                        r_out_pos_mode <= r_pos_mode;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.cmd_vel_x        = r_out_cmd[0];
    assign o_res.cmd_vel_y        = r_out_cmd[1];
    assign o_res.cmd_vel_z        = r_out_cmd[2];
    assign o_res.limit_tripped    = r_out_tripped;
    assign o_res.in_position_mode = r_out_pos_mode;

endmodule

FILE: design/cvs_mac.sv
// shared subtract-and-multiply unit with registered product
module cvs_mac (
    input  logic            i_clk,
    input  logic            i_en,
    input  cvs_pkg::t_coord i_minuend,
    input  cvs_pkg::t_coord i_subtrahend,
    input  cvs_pkg::t_weight i_scale,
    output cvs_pkg::t_prod  o_prod
);
    import cvs_pkg::*;

    logic signed [COORD_W:0]         w_diff;
    logic signed [COORD_W+WEIGHT_W+1:0] w_full;
    t_prod                           r_prod;

    assign w_diff = {i_minuend[COORD_W-1], i_minuend}
                  - {i_subtrahend[COORD_W-1], i_subtrahend};
    assign w_full = w_diff * $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= w_full[PROD_W-1:0];
        end
    end

    assign o_prod = r_prod;

endmodule

FILE: design/cvs_checker.sv
// port-level checks of the velocity command shaper, bound to the top level
module cvs_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_ready,
    input logic            i_out_valid,
    input logic            i_out_ready,
    input cvs_pkg::t_coord i_cmd_x,
    input logic            i_tripped
);

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // reset leaves the block ready for an item
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready right after reset");

    // a new result only comes out of a tick in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("result appeared while no tick was in progress");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cmd_x)
                                        && $stable(i_tripped))
        else $error("stalled result changed");

endmodule

bind cartesian_velocity_command_shaper cvs_checker u_cvs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_cmd_x     (o_res.cmd_vel_x),
    .i_tripped   (o_res.limit_tripped)
);

FILE: dv/cartesian_velocity_command_shaper_test.sv
// self-checking testbench of the velocity command shaper: directed and random items vs a predictor
`timescale 1ns / 100ps

module cartesian_velocity_command_shaper_test;
    import cvs_pkg::*;

    localparam int     SETTLE_CYCLES  = 24;
    localparam int     LONG_HOLD      = 300;
    localparam int     PRESSURE_TICKS = 40;
    localparam int     RAND_PHASES    = 8;
    localparam int     SEQS_PER_PHASE = 11;
    localparam int     NUM_REGS       = CFG_SMOOTH_W + 1;
    localparam longint JITTER_MAX     = 64'sh3FFF_FFFF;

    localparam t_coord  COORD_MAX = 32'sh7FFF_FFFF;
    localparam t_coord  COORD_MIN = 32'sh8000_0000;
    localparam t_action ACT_RSVD_LO  = 3'd5;
    localparam t_action ACT_RSVD_MID = 3'd6;
    localparam t_action ACT_RSVD_HI  = 3'd7;

    typedef struct {
        t_coord vel_x;
        t_coord vel_y;
        t_coord vel_z;
        logic   tripped;
        logic   pos_mode;
    } t_cmd_sample;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cvs_item_if   item_ch ();
    cvs_result_if res_ch ();
    cvs_cfg_if    cfg_ch ();

    cartesian_velocity_command_shaper dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // predictor copy of the registers
    t_gain  shp_gain               = 16'd256;
    longint shp_lim_vel [NUM_AXES] = '{default: 6554};
    longint shp_lim_disp           = 6554;
    longint shp_lim_pos            = 65536;
    longint shp_weight             = 6554;

    // predictor copy of the block state
    t_coord shp_target [NUM_AXES] = '{default: '0};
    t_coord shp_goal   [NUM_AXES] = '{default: '0};
    t_coord shp_cmd    [NUM_AXES] = '{default: '0};
    t_coord shp_start_x  = '0;
    bit     shp_pos_mode = 1'b0;
    bit     shp_relatch  = 1'b1;
    bit     shp_active   = 1'b0;

    t_cmd_sample expected_cmds [$];
    int          mismatches     = 0;
    int unsigned hold_off_left  = 0;
    bit          hold_off_req   = 1'b0;
    bit          hold_off_ack   = 1'b0;
    int unsigned res_stall_left = 0;
    bit          item_gaps_on   = 1'b1;
    bit          res_stalls_on  = 1'b1;

    function automatic longint clamp_mag(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic t_coord sat_coord(longint v);
        if (v > longint'(COORD_MAX)) return COORD_MAX;
        if (v < longint'(COORD_MIN)) return COORD_MIN;
        return t_coord'(v);
    endfunction

    function automatic void store_reg(t_cfg_idx idx, logic [31:0] data);
        case (idx)
            CFG_PROP_GAIN:  shp_gain = data[GAIN_W-1:0];
            CFG_LIM_VEL_X:  shp_lim_vel[0] = longint'(data[LIMIT_W-1:0]);
            CFG_LIM_VEL_Y:  shp_lim_vel[1] = longint'(data[LIMIT_W-1:0]);
            CFG_LIM_VEL_Z:  shp_lim_vel[2] = longint'(data[LIMIT_W-1:0]);
            CFG_LIM_DISP_X: shp_lim_disp = longint'(data[LIMIT_W-1:0]);
            CFG_LIM_POS_X:  shp_lim_pos = longint'($signed(data));
            CFG_SMOOTH_W:   shp_weight = longint'(data[WEIGHT_W-1:0]);
            default: ;
        endcase
    endfunction

    // updates the shaper state for one accepted item and queues the command it causes
    function automatic void predict_item(t_action act, t_coord cx, t_coord cy, t_coord cz);
        t_coord      c [NUM_AXES];
        longint      err, p_term, travel, w, acc;
        bit          trip;
        int          i;
        t_cmd_sample smp;
        c[0] = cx;
        c[1] = cy;
        c[2] = cz;
        trip = 1'b0;
        if (act == ACT_ACTIVATE) begin
            for (i = 0; i < NUM_AXES; i++) begin
                shp_target[i] = '0;
                shp_cmd[i]    = '0;
            end
            shp_active   = 1'b1;
            shp_relatch  = 1'b1;
            shp_pos_mode = 1'b0;
            return;
        end
        if (act == ACT_DEACTIVATE) begin
            shp_active   = 1'b0;
            shp_pos_mode = 1'b0;
            return;
        end
        if (act > ACT_DEACTIVATE || !shp_active) return;
        if (act == ACT_SPEED) begin
            for (i = 0; i < NUM_AXES; i++)
                shp_target[i] = t_coord'(clamp_mag(longint'(c[i]), shp_lim_vel[i]));
            shp_pos_mode = 1'b0;
            shp_relatch  = 1'b1;
            return;
        end
        if (act == ACT_GOAL) begin
            for (i = 0; i < NUM_AXES; i++)
                shp_goal[i] = c[i];
            shp_pos_mode = 1'b1;
            shp_relatch  = 1'b1;
            return;
        end
        if (shp_pos_mode) begin
            for (i = 0; i < NUM_AXES; i++) begin
                err    = longint'(shp_goal[i]) - longint'(c[i]);
                p_term = (longint'(shp_gain) * err) >>> 8;
                shp_target[i] = t_coord'(clamp_mag(p_term, shp_lim_vel[i]));
            end
        end
        if (shp_relatch) begin
            shp_start_x = c[0];
            shp_relatch = 1'b0;
        end
        travel = longint'(shp_start_x) - longint'(c[0]);
        if (travel < 0) travel = -travel;
        if (travel > shp_lim_disp || longint'(c[0]) > shp_lim_pos) begin
            trip = 1'b1;
            for (i = 0; i < NUM_AXES; i++)
                shp_target[i] = '0;
        end
        w = (shp_weight > W_ONE) ? longint'(W_ONE) : shp_weight;
        for (i = 0; i < NUM_AXES; i++) begin
            acc = (longint'(W_ONE) - w) * longint'(shp_cmd[i]) + w * longint'(shp_target[i])
                  + longint'(ROUND_HALF);
            shp_cmd[i] = t_coord'(acc >>> 16);
        end
        smp.vel_x    = shp_cmd[0];
        smp.vel_y    = shp_cmd[1];
        smp.vel_z    = shp_cmd[2];
        smp.tripped  = trip;
        smp.pos_mode = shp_pos_mode;
        expected_cmds.push_back(smp);
    endfunction

    function automatic t_coord jitter(t_coord center, longint spread);
        longint span, off;
        span = (spread > JITTER_MAX) ? JITTER_MAX : spread;
        off  = longint'($urandom_range(0, 32'(2 * span))) - span;
        return sat_coord(longint'(center) + off);
    endfunction

    function automatic t_coord rand_coord();
        case ($urandom_range(0, 5))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return jitter('0, 1 << 17);
            default: return t_coord'($urandom());
        endcase
    endfunction

    // speeds mostly spread out to a little past the axis limit so both sides of the clamp get hit
    function automatic t_coord rand_speed(int axis);
        if ($urandom_range(0, 3) == 0) return rand_coord();
        return jitter('0, shp_lim_vel[axis] + shp_lim_vel[axis] / 8 + 1);
    endfunction

    function automatic void check_field(string name, logic signed [COORD_W-1:0] want,
                                        logic signed [COORD_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected %0d, actual %0d", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_cmd_sample want;
        if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
            if (expected_cmds.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result transfer with nothing expected: vel %0d %0d %0d",
                             res_ch.cmd_vel_x, res_ch.cmd_vel_y, res_ch.cmd_vel_z);
            end else begin
                want = expected_cmds.pop_front();
                check_field("cmd_vel_x", want.vel_x, res_ch.cmd_vel_x);
                check_field("cmd_vel_y", want.vel_y, res_ch.cmd_vel_y);
                check_field("cmd_vel_z", want.vel_z, res_ch.cmd_vel_z);
                check_field("limit_tripped", t_coord'(want.tripped),
                            t_coord'(res_ch.limit_tripped));
                check_field("in_position_mode", t_coord'(want.pos_mode),
                            t_coord'(res_ch.in_position_mode));
            end
        end
    end

    // a toggle of the request starts a long hold-off
    always @(posedge i_clk) begin : count_hold_off
        if (hold_off_ack != hold_off_req) begin
            hold_off_ack  <= hold_off_req;
            hold_off_left <= LONG_HOLD;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    always @(posedge i_clk) begin : drive_res_ready
        if (res_stall_left != 0) begin
            res_stall_left <= res_stall_left - 1;
            res_ch.ready   <= 1'b0;
        end else if (res_stalls_on && $urandom_range(0, 5) == 0) begin
            // start a stall burst; res_stall_left holds what remains of it
            res_stall_left <= $urandom_range(0, 12);
            res_ch.ready   <= 1'b0;
        end else begin
            res_ch.ready <= (hold_off_left == 0);
        end
    end

    task automatic send_item(t_action act, t_coord cx, t_coord cy, t_coord cz);
        int unsigned gap;
        gap = 0;
        if (item_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
        if (gap != 0) begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.action  <= act;
        item_ch.coord_x <= cx;
        item_ch.coord_y <= cy;
        item_ch.coord_z <= cz;
        do @(posedge i_clk); while (item_ch.ready !== 1'b1);
        predict_item(act, cx, cy, cz);
    endtask

    // stop offering, let every expected command arrive and the block go quiet
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [31:0] gain, logic [31:0] vel_x, logic [31:0] vel_y,
                                logic [31:0] vel_z, logic [31:0] disp, logic [31:0] pos,
                                logic [31:0] weight);
        logic [31:0] vals [NUM_REGS];
        t_cfg_idx    idx;
        vals[CFG_PROP_GAIN]  = gain;
        vals[CFG_LIM_VEL_X]  = vel_x;
        vals[CFG_LIM_VEL_Y]  = vel_y;
        vals[CFG_LIM_VEL_Z]  = vel_z;
        vals[CFG_LIM_DISP_X] = disp;
        vals[CFG_LIM_POS_X]  = pos;
        vals[CFG_SMOOTH_W]   = weight;
        for (idx = CFG_PROP_GAIN; idx <= CFG_SMOOTH_W; idx++) begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx;
            cfg_ch.data  <= vals[idx];
            do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
            store_reg(idx, vals[idx]);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_vel_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom_range(1, 1 << 20);
            default: return $urandom() & 32'h7FFF_FFFF;
        endcase
    endfunction

    task automatic randomize_regs();
        logic [31:0] gain, disp, pos, weight;
        if ($urandom_range(0, 7) == 0) begin
            // raw words: bits above each field width must be dropped
            program_regs($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom());
        end else begin
            case ($urandom_range(0, 4))
                0: gain = '0;
                1: gain = 32'h0000_FFFF;
                2: gain = $urandom_range(1, 1023);
                default: gain = $urandom_range(0, 16'hFFFF);
            endcase
            case ($urandom_range(0, 5))
                0: disp = '0;
                1: disp = 32'h7FFF_FFFF;
                default: disp = $urandom_range(1 << 12, 1 << 24);
            endcase
            case ($urandom_range(0, 5))
                0: pos = 32'h8000_0000;
                1: pos = 32'h7FFF_FFFF;
                2: pos = $urandom();
                default: pos = 32'h7FFF_FFFF - $urandom_range(0, 1 << 16);
            endcase
            case ($urandom_range(0, 4))
                0: weight = '0;
                1: weight = W_ONE;
                2: weight = $urandom_range(W_ONE + 1, (1 << WEIGHT_W) - 1);
                default: weight = $urandom_range(1, W_ONE - 1);
            endcase
            program_regs(gain, rand_vel_limit(), rand_vel_limit(), rand_vel_limit(), disp,
                         pos, weight);
        end
    endtask

    task automatic test_ignored_while_inactive();
        send_item(ACT_TICK, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_SPEED, COORD_MAX, COORD_MAX, COORD_MAX);
        send_item(ACT_GOAL, COORD_MIN, COORD_MIN, COORD_MIN);
        send_item(ACT_RSVD_LO, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_RSVD_MID, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_RSVD_HI, rand_coord(), rand_coord(), rand_coord());
        wait_idle();
    endtask

    // reset register values: speed clamp, start latch, travel and position trips
    task automatic test_velocity_mode();
        send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_SPEED, COORD_MAX, COORD_MIN, '0);
        send_item(ACT_TICK, '0, rand_coord(), rand_coord());
        send_item(ACT_TICK, 32'sd6554, rand_coord(), rand_coord());
        send_item(ACT_TICK, 32'sd6555, rand_coord(), rand_coord());
        send_item(ACT_TICK, -32'sd6555, rand_coord(), rand_coord());
        // zeroed targets stay until a new target comes
        send_item(ACT_TICK, '0, rand_coord(), rand_coord());
        send_item(ACT_SPEED, -32'sd1, 32'sd1, 32'sd12345);
        send_item(ACT_TICK, 32'sd100000, rand_coord(), rand_coord());
        send_item(ACT_DEACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_TICK, '0, '0, '0);
        send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_TICK, '0, rand_coord(), rand_coord());
        wait_idle();
    endtask

    task automatic test_position_mode();
        // widest gain and limits, weight above one
        program_regs(32'h0000_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0001_FFFF);
        send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_GOAL, COORD_MAX, COORD_MIN, '0);
        send_item(ACT_TICK, COORD_MIN, COORD_MAX, '0);
        send_item(ACT_TICK, '0, '0, -32'sd1);
        wait_idle();
        // everything at the other end
        program_regs('0, '0, '0, '0, '0, 32'h8000_0000, '0);
        send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_GOAL, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_TICK, COORD_MIN, rand_coord(), rand_coord());
        send_item(ACT_TICK, '0, rand_coord(), rand_coord());
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        int k;
        program_regs(32'd256, 32'd1 << 18, 32'd1 << 18, 32'd1 << 18, 32'd1 << 20,
                     32'h7FFF_FFFF, 32'd20000);
        send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        send_item(ACT_SPEED, rand_speed(0), rand_speed(1), rand_speed(2));
        hold_off_req <= !hold_off_req;
        for (k = 0; k < PRESSURE_TICKS; k++)
            send_item(ACT_TICK, jitter('0, 1 << 18), rand_coord(), rand_coord());
        wait_idle();
    endtask

    // a target or another item, then a run of ticks that mostly stay inside the travel window
    task automatic run_sequence();
        int     kind;
        int     n_ticks;
        t_coord base, gy, gz;
        longint half;
        if (!shp_active) send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        kind = $urandom_range(0, 19);
        half = shp_lim_disp / 2;
        base = rand_coord();
        if (longint'(base) > shp_lim_pos) base = sat_coord(shp_lim_pos - half);
        gy = rand_coord();
        gz = rand_coord();
        if (kind < 9) begin
            send_item(ACT_SPEED, rand_speed(0), rand_speed(1), rand_speed(2));
        end else if (kind < 18) begin
            send_item(ACT_GOAL, jitter(base, 1 << 16), gy, gz);
        end else if (kind == 18) begin
            send_item(ACT_DEACTIVATE, rand_coord(), rand_coord(), rand_coord());
            send_item(ACT_TICK, rand_coord(), rand_coord(), rand_coord());
            send_item(ACT_SPEED, rand_coord(), rand_coord(), rand_coord());
            send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
        end else begin
            send_item(t_action'($urandom_range(0, (1 << ACTION_W) - 1)), rand_coord(),
                      rand_coord(), rand_coord());
        end
        n_ticks = $urandom_range(2, 9);
        repeat (n_ticks) begin
            if ($urandom_range(0, 9) == 0)
                send_item(ACT_TICK, rand_coord(), rand_coord(), rand_coord());
            else
                send_item(ACT_TICK, jitter(base, half), jitter(gy, 1 << 16),
                          jitter(gz, 1 << 16));
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            wait_idle();
            randomize_regs();
            if (phase == RAND_PHASES - 1) begin
                item_gaps_on  <= 1'b0;
                res_stalls_on <= 1'b0;
            end
            send_item(ACT_ACTIVATE, rand_coord(), rand_coord(), rand_coord());
            repeat (SEQS_PER_PHASE) run_sequence();
        end
    endtask

    initial begin
        item_ch.valid   = 1'b0;
        item_ch.action  = ACT_TICK;
        item_ch.coord_x = '0;
        item_ch.coord_y = '0;
        item_ch.coord_z = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = CFG_PROP_GAIN;
        cfg_ch.data     = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_ignored_while_inactive();
        test_velocity_mode();
        test_position_mode();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("cartesian_velocity_command_shaper_test: PASS");
        else
            $display("cartesian_velocity_command_shaper_test: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("cartesian_velocity_command_shaper_test: FAIL");
        $finish;
    end

endmodule
